>>> hdl/aovl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aovl_pkg
// Shared types and constants for the windowed alpha overlay block.
// ----------------------------------------------------------------------------
package aovl_pkg;

    localparam int CHAN_W     = 8;
    localparam int OFFSET_W   = 12;
    localparam int CFG_DIM_W  = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVERLAY_X      = 3'd0,
        REG_OVERLAY_Y      = 3'd1,
        REG_IMAGE_WIDTH    = 3'd2,
        REG_IMAGE_HEIGHT   = 3'd3,
        REG_OVERLAY_WIDTH  = 3'd4,
        REG_OVERLAY_HEIGHT = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [OFFSET_W-1:0]  overlay_x;
        logic [OFFSET_W-1:0]  overlay_y;
        logic [CFG_DIM_W-1:0] image_width;
        logic [CFG_DIM_W-1:0] image_height;
        logic [CFG_DIM_W-1:0] overlay_width;
        logic [CFG_DIM_W-1:0] overlay_height;
    } cfg_t;

    typedef struct packed {
        logic in_window;
        logic frame_end;
    } pix_flags_t;

endpackage

>>> hdl/windowed_rgba_alpha_overlay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rgba_alpha_overlay
// Composites a foreground pixel over a background pixel inside a window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one background pixel and the
//   matching foreground pixel per word, background in raster order.
//   Output channel (out_valid/out_ready) carries the composited pixel with
//   in_window and frame_end flags, one word per input word.
//   Config channel (cfg_valid/cfg_ready) writes one register per word;
//   cfg_ready is always high. Write only while the block is idle.
// Path: each accepted word passes the input register, then the blend
//   multipliers and the result register, which drives out_valid.
// Throughput: one pixel per clock while out_ready is high; set by the
//   two-stage pipeline, advancing when the result register is empty or taken.
// Reset: column and row counters go to zero, config registers to their
//   defaults (window at 0,0; 640x480 image and overlay), pipeline empty.
// Stall: with out_ready low the result holds; the input register still
//   takes one word, after which in_ready drops until the output drains.
// ----------------------------------------------------------------------------
module windowed_rgba_alpha_overlay #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aovl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aovl_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [aovl_pkg::CHAN_W-1:0]     bg_blue,
    input  logic [aovl_pkg::CHAN_W-1:0]     bg_green,
    input  logic [aovl_pkg::CHAN_W-1:0]     bg_red,
    input  logic [aovl_pkg::CHAN_W-1:0]     bg_alpha,
    input  logic [aovl_pkg::CHAN_W-1:0]     fg_blue,
    input  logic [aovl_pkg::CHAN_W-1:0]     fg_green,
    input  logic [aovl_pkg::CHAN_W-1:0]     fg_red,
    input  logic [aovl_pkg::CHAN_W-1:0]     fg_alpha,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [aovl_pkg::CHAN_W-1:0]     out_blue,
    output logic [aovl_pkg::CHAN_W-1:0]     out_green,
    output logic [aovl_pkg::CHAN_W-1:0]     out_red,
    output logic [aovl_pkg::CHAN_W-1:0]     out_alpha,
    output logic                            in_window,
    output logic                            frame_end
);
    import aovl_pkg::*;

    cfg_t       cfg_reg;
    pix_flags_t win_flags;

    logic       accept;
    logic       advance;

    // input stage
    logic              s1_valid_reg;
    pix_flags_t        s1_flags_reg;
    logic [CHAN_W-1:0] s1_bg_b_reg, s1_bg_g_reg, s1_bg_r_reg, s1_bg_a_reg;
    logic [CHAN_W-1:0] s1_fg_b_reg, s1_fg_g_reg, s1_fg_r_reg, s1_fg_a_reg;

    // blend results
    logic [CHAN_W-1:0] mix_b, mix_g, mix_r, mix_a;
    logic [CHAN_W-1:0] res_b_next, res_g_next, res_r_next, res_a_next;

    // result stage
    logic              out_valid_reg;
    pix_flags_t        out_flags_reg;
    logic [CHAN_W-1:0] out_b_reg, out_g_reg, out_r_reg, out_a_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overlay_x      <= '0;
            cfg_reg.overlay_y      <= '0;
            cfg_reg.image_width    <= CFG_DIM_W'(640);
            cfg_reg.image_height   <= CFG_DIM_W'(480);
            cfg_reg.overlay_width  <= CFG_DIM_W'(640);
            cfg_reg.overlay_height <= CFG_DIM_W'(480);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_OVERLAY_X:      cfg_reg.overlay_x      <= cfg_data[OFFSET_W-1:0];
                REG_OVERLAY_Y:      cfg_reg.overlay_y      <= cfg_data[OFFSET_W-1:0];
                REG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_data[CFG_DIM_W-1:0];
                REG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_data[CFG_DIM_W-1:0];
                REG_OVERLAY_WIDTH:  cfg_reg.overlay_width  <= cfg_data[CFG_DIM_W-1:0];
                REG_OVERLAY_HEIGHT: cfg_reg.overlay_height <= cfg_data[CFG_DIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    aovl_window #(
        .MAX_DIM (MAX_DIM)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .cfg   (cfg_reg),
        .flags (win_flags)
    );

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg <= win_flags;
            s1_bg_b_reg  <= bg_blue;
            s1_bg_g_reg  <= bg_green;
            s1_bg_r_reg  <= bg_red;
            s1_bg_a_reg  <= bg_alpha;
            s1_fg_b_reg  <= fg_blue;
            s1_fg_g_reg  <= fg_green;
            s1_fg_r_reg  <= fg_red;
            s1_fg_a_reg  <= fg_alpha;
        end
    end

    // ---------------- blend ----------------
    aovl_blend u_blend_b (
        .alpha (s1_fg_a_reg), .fg (s1_fg_b_reg), .bg (s1_bg_b_reg), .res (mix_b)
    );
    aovl_blend u_blend_g (
        .alpha (s1_fg_a_reg), .fg (s1_fg_g_reg), .bg (s1_bg_g_reg), .res (mix_g)
    );
    aovl_blend u_blend_r (
        .alpha (s1_fg_a_reg), .fg (s1_fg_r_reg), .bg (s1_bg_r_reg), .res (mix_r)
    );
    // alpha channel blends against an opaque foreground
    aovl_blend u_blend_a (
        .alpha (s1_fg_a_reg), .fg (CHAN_MAX), .bg (s1_bg_a_reg), .res (mix_a)
    );

    assign res_b_next = s1_flags_reg.in_window ? mix_b : s1_bg_b_reg;
    assign res_g_next = s1_flags_reg.in_window ? mix_g : s1_bg_g_reg;
    assign res_r_next = s1_flags_reg.in_window ? mix_r : s1_bg_r_reg;
    assign res_a_next = s1_flags_reg.in_window ? mix_a : s1_bg_a_reg;

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_flags_reg <= s1_flags_reg;
            out_b_reg     <= res_b_next;
            out_g_reg     <= res_g_next;
            out_r_reg     <= res_r_next;
            out_a_reg     <= res_a_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_blue  = out_b_reg;
    assign out_green = out_g_reg;
    assign out_red   = out_r_reg;
    assign out_alpha = out_a_reg;
    assign in_window = out_flags_reg.in_window;
    assign frame_end = out_flags_reg.frame_end;

    // ---------------- assertions ----------------
    // a held input stage keeps its word while the result register is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_bg_b_reg))
        else $error("input stage lost a word while stalled");

    // pixels outside the window pass the background through
    a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg && !s1_flags_reg.in_window
        |=> out_blue == $past(s1_bg_b_reg) && out_alpha == $past(s1_bg_a_reg))
        else $error("background not passed through outside window");

    // an opaque foreground replaces the background exactly
    a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg && s1_flags_reg.in_window && s1_fg_a_reg == CHAN_MAX
        |=> out_green == $past(s1_fg_g_reg) && out_alpha == CHAN_MAX)
        else $error("opaque blend does not match foreground");

    // a result only appears after a word sat in the input stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result valid without a source word");

endmodule

>>> hdl/aovl_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aovl_blend
// One channel of the over operator: round((a*f + (255-a)*b) / 255).
// ----------------------------------------------------------------------------
module aovl_blend (
    input  logic [aovl_pkg::CHAN_W-1:0] alpha,
    input  logic [aovl_pkg::CHAN_W-1:0] fg,
    input  logic [aovl_pkg::CHAN_W-1:0] bg,
    output logic [aovl_pkg::CHAN_W-1:0] res
);
    import aovl_pkg::*;

    localparam int PROD_W = 2 * CHAN_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [CHAN_W-1:0] inv_alpha;
    logic [PROD_W-1:0] fg_prod;
    logic [PROD_W-1:0] bg_prod;
    logic [SUM_W-1:0]  num_rnd;
    logic [SUM_W-1:0]  quot_sum;

    assign inv_alpha = CHAN_MAX - alpha;
    assign fg_prod   = PROD_W'(alpha) * PROD_W'(fg);
    assign bg_prod   = PROD_W'(inv_alpha) * PROD_W'(bg);

    // numerator plus half of 255 for round to nearest
    assign num_rnd = SUM_W'(fg_prod) + SUM_W'(bg_prod) + SUM_W'(CHAN_MAX >> 1);

    // exact divide by 255 for values below 65535
    assign quot_sum = num_rnd + (num_rnd >> CHAN_W) + SUM_W'(1);
    assign res      = quot_sum[CHAN_W +: CHAN_W];

endmodule

>>> hdl/aovl_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aovl_window
// Raster position counters and overlay window membership test.
// ----------------------------------------------------------------------------
module aovl_window #(
    parameter int MAX_DIM = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  aovl_pkg::cfg_t         cfg,
    output aovl_pkg::pix_flags_t   flags
);
    import aovl_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DIM_W = CNT_W + 1;
    localparam int CMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;

    logic [CMP_W-1:0] img_w, img_h;
    logic [CMP_W-1:0] col_ext, row_ext;
    logic [CMP_W-1:0] col_off, row_off;
    logic [CMP_W-1:0] col_plus, row_plus;
    logic             col_in, row_in;
    logic             line_last, frame_last;

    // zero size acts as one, oversize clamps to the maximum
    always_comb
    begin
        if (cfg.image_width == '0)
            img_w = CMP_W'(1);
        else if (CMP_W'(cfg.image_width) > CMP_W'(MAX_DIM))
            img_w = CMP_W'(MAX_DIM);
        else
            img_w = CMP_W'(cfg.image_width);

        if (cfg.image_height == '0)
            img_h = CMP_W'(1);
        else if (CMP_W'(cfg.image_height) > CMP_W'(MAX_DIM))
            img_h = CMP_W'(MAX_DIM);
        else
            img_h = CMP_W'(cfg.image_height);
    end

    assign col_ext  = CMP_W'(col_reg);
    assign row_ext  = CMP_W'(row_reg);
    assign col_off  = col_ext - CMP_W'(cfg.overlay_x);
    assign row_off  = row_ext - CMP_W'(cfg.overlay_y);
    assign col_plus = col_ext + CMP_W'(1);
    assign row_plus = row_ext + CMP_W'(1);

    assign col_in = (col_ext >= CMP_W'(cfg.overlay_x)) &&
                    (col_off < CMP_W'(cfg.overlay_width)) && (col_ext < img_w);
    assign row_in = (row_ext >= CMP_W'(cfg.overlay_y)) &&
                    (row_off < CMP_W'(cfg.overlay_height)) && (row_ext < img_h);

    assign line_last  = col_plus >= img_w;
    assign frame_last = line_last && (row_plus >= img_h);

    assign flags.in_window = col_in && row_in;
    assign flags.frame_end = frame_last;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (line_last)
        begin
            col_next = '0;
            row_next = (row_plus >= img_h) ? '0 : row_plus[CNT_W-1:0];
        end
        else
        begin
            col_next = col_plus[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule
